// ===== design/pfm_pkg.sv =====
// Package for the page frame manager: actions, status codes, shared constants.
// No dependencies.
package pfm_pkg;
  localparam int unsigned NumFramesDef = 16;
  localparam int unsigned PinBitsDef = 8;
  localparam int unsigned SweepTurns = 2;
  localparam int unsigned MaxResults = 16;

  typedef enum logic [2:0] {
    ActGet = 3'd0, ActAlloc = 3'd1, ActDirty = 3'd2, ActUnpin = 3'd3,
    ActForce = 3'd4, ActForceFile = 3'd5
  } action_e;

  typedef enum logic [2:0] {
    StOk = 3'd0, StNotIn = 3'd1, StUnpinned = 3'd2, StNoFrame = 3'd3,
    StAlready = 3'd4, StPinLimit = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    SIdle, SScan, SOut, SSweep, SFile, SFileEnd
  } state_e;
endpackage

// ===== design/page_frame_manager_clock.sv =====
// Top level of the page frame manager with clock replacement.
// Depends on pfm_pkg.
//
// Usage: one request (action_i, file_id_i, page_num_i) is taken on the input
// channel when in_valid_i is high and in_stall_o is low. Each request gives
// one or more results on the output channel, taken when out_valid_o is high
// and out_stall_i is low; last_o marks the final one. Requests are worked
// one at a time; in_stall_o stays high until the last result has been taken.
// Tags, pin counts and flags live in a frame memory with a registered read.
// The lookup reads the memory one frame a cycle. A miss with no free frame
// then runs the clock sweep, which visits at most 2 * NUM_FRAMES frames.
// An unknown action skips the lookup and answers from the output state.
// A force whole file gives its final result from the end state once the scan
// is over; each earlier result goes out when the scan finds the next one.
// Valid bits and the clock hand are cleared at reset. A frame entry is written
// in full whenever a frame is taken, so the memory needs no clearing pass.
// While the receiver stalls, the result register holds; a force whole file
// scan pauses when it has a further result to hand over.
module page_frame_manager_clock
  import pfm_pkg::*;
#(
  parameter int unsigned NUM_FRAMES = NumFramesDef,
  parameter int unsigned PIN_BITS = PinBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  action_i,
  input  logic [7:0]  file_id_i,
  input  logic [23:0] page_num_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [3:0]  frame_o,
  output logic        fill_needed_o,
  output logic        writeback_needed_o,
  output logic [7:0]  wb_file_id_o,
  output logic [23:0] wb_page_num_o,
  output logic        last_o
);
  localparam int unsigned FW = $clog2(NUM_FRAMES);
  localparam int unsigned EW = 8 + 24 + PIN_BITS + 2;
  localparam logic [FW-1:0] LastIdx = FW'(NUM_FRAMES - 1);
  localparam logic [PIN_BITS-1:0] PinMax = '1;
  localparam int unsigned SW = $clog2(SweepTurns * NUM_FRAMES + 1);
  localparam logic [SW-1:0] SweepLimit = SW'(SweepTurns * NUM_FRAMES);
  localparam logic [4:0] ResLimit = 5'(MaxResults);

  // Entry layout: {file, page, pin, dirty, ref}.
  logic [EW-1:0] mem [NUM_FRAMES];
  logic [EW-1:0] rd_q;
  logic          we;
  logic [FW-1:0] wa, ra;
  logic [EW-1:0] wd;
  logic [NUM_FRAMES-1:0] valid_q, valid_d;

  state_e state_q, state_d;
  logic [2:0]  act_q;
  logic [7:0]  file_q;
  logic [23:0] page_q;
  logic [FW-1:0] idx_q, idx_d, hand_q, hand_d;
  logic [SW-1:0] cnt_q, cnt_d;
  logic        hit_q, hit_d, free_q, free_d;
  logic [FW-1:0] hidx_q, hidx_d, fidx_q, fidx_d;
  logic [4:0]  nres_q, nres_d;
  logic        pend_v_q, pend_v_d;
  logic [FW-1:0] pend_idx_q, pend_idx_d;
  logic [23:0] pend_page_q, pend_page_d;

  logic [2:0]  st_q, st_d;
  logic [3:0]  fr_q, fr_d;
  logic        fill_q, fill_d, wb_q, wb_d, last_q, last_d;
  logic [7:0]  wbf_q, wbf_d;
  logic [23:0] wbp_q, wbp_d;
  logic        ov_q, ov_d;

  logic [7:0]  r_file;
  logic [23:0] r_page;
  logic [PIN_BITS-1:0] r_pin;
  logic        r_dirty, r_ref;
  assign {r_file, r_page, r_pin, r_dirty, r_ref} = rd_q;

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    rd_q <= mem[ra];
  end

  logic accept, out_free, scan_last, scan_hit, load_act, need_sweep;
  logic sweep_take, sweep_done, file_hit, file_block;

  assign in_stall_o = (state_q != SIdle) || ov_q;
  assign accept     = in_valid_i && !in_stall_o;
  // The result register may be loaded when it is empty or is taken this cycle.
  assign out_free   = !ov_q || !out_stall_i;
  assign scan_last  = (idx_q == LastIdx);
  assign scan_hit   = valid_q[idx_q] && (r_file == file_q) && (r_page == page_q);
  assign load_act   = (act_q == ActGet) || (act_q == ActAlloc);
  assign need_sweep = load_act && !hit_q && !free_q;
  assign sweep_take = (r_pin == '0) && !r_ref;
  assign sweep_done = (cnt_q + SW'(1)) == SweepLimit;
  assign file_hit   = valid_q[idx_q] && (r_file == file_q) && r_dirty &&
                      (nres_q < ResLimit);
  // A second writeback is found while the previous one cannot be handed over.
  assign file_block = file_hit && pend_v_q && !out_free;

  // A freshly loaded frame: pinned once, clean, referenced.
  function automatic logic [EW-1:0] new_entry(input logic [7:0] f,
                                               input logic [23:0] p);
    return {f, p, PIN_BITS'(1), 1'b0, 1'b1};
  endfunction

  function automatic logic [FW-1:0] hand_step(input logic [FW-1:0] h);
    return (h == LastIdx) ? '0 : h + FW'(1);
  endfunction

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SIdle: begin
        if (accept) begin
          if (action_i == ActForceFile) state_d = SFile;
          else if (action_i > ActForceFile) state_d = SOut;
          else state_d = SScan;
        end
      end
      SScan: begin
        if (scan_last) state_d = SOut;
      end
      SOut: begin
        state_d = need_sweep ? SSweep : SIdle;
      end
      SSweep: begin
        if (sweep_take || sweep_done) state_d = SIdle;
      end
      SFile: begin
        if (!file_block && scan_last) state_d = SFileEnd;
      end
      SFileEnd: begin
        if (out_free) state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  // Memory accesses, bookkeeping and the result register.
  always_comb begin
    idx_d = idx_q; hand_d = hand_q; cnt_d = cnt_q;
    hit_d = hit_q; free_d = free_q; hidx_d = hidx_q; fidx_d = fidx_q;
    nres_d = nres_q; valid_d = valid_q;
    pend_v_d = pend_v_q; pend_idx_d = pend_idx_q; pend_page_d = pend_page_q;
    st_d = st_q; fr_d = fr_q; fill_d = fill_q; wb_d = wb_q; last_d = last_q;
    wbf_d = wbf_q; wbp_d = wbp_q; ov_d = ov_q && out_stall_i;
    we = 1'b0; wa = idx_q; wd = rd_q; ra = idx_q;
    unique case (state_q)
      SIdle: begin
        ra = '0;
        if (accept) begin
          idx_d = '0; hit_d = 1'b0; free_d = 1'b0; nres_d = '0; pend_v_d = 1'b0;
          cnt_d = '0;
          st_d = StNotIn; fr_d = '0; fill_d = 1'b0; wb_d = 1'b0;
          wbf_d = '0; wbp_d = '0; last_d = 1'b1;
        end
      end
      SScan: begin
        // rd_q holds entry idx_q; ra prefetches the next one.
        ra = idx_q + FW'(1);
        if (scan_hit && !hit_q) begin
          hit_d = 1'b1; hidx_d = idx_q;
        end
        if (!valid_q[idx_q] && !free_q) begin
          free_d = 1'b1; fidx_d = idx_q;
        end
        if (scan_last) begin
          ra = hit_d ? hidx_d : fidx_d;
        end else begin
          idx_d = idx_q + FW'(1);
        end
      end
      SOut: begin
        // rd_q holds the hit frame, if any; unknown actions ignore it.
        ov_d = !need_sweep;
        if (act_q > ActForceFile) begin
          st_d = StNotIn;
        end else if (load_act) begin
          if (hit_q) begin
            fr_d = 4'(hidx_q);
            if (act_q == ActAlloc) begin
              st_d = StAlready;
            end else if (r_pin == PinMax) begin
              st_d = StPinLimit;
            end else begin
              st_d = StOk; we = 1'b1; wa = hidx_q;
              wd = {r_file, r_page, r_pin + PIN_BITS'(1), r_dirty, 1'b1};
            end
          end else if (free_q) begin
            st_d = StOk; fr_d = 4'(fidx_q); fill_d = (act_q == ActGet);
            we = 1'b1; wa = fidx_q; wd = new_entry(file_q, page_q);
            valid_d[fidx_q] = 1'b1;
          end else begin
            // Every frame is taken: start the clock sweep one past the hand.
            hand_d = hand_step(hand_q);
            ra = hand_step(hand_q);
            cnt_d = '0;
          end
        end else if (!hit_q) begin
          st_d = StNotIn;
        end else begin
          fr_d = 4'(hidx_q); st_d = StOk; wa = hidx_q;
          if (act_q == ActForce) begin
            if (r_dirty) begin
              wb_d = 1'b1; wbf_d = r_file; wbp_d = r_page; we = 1'b1;
              wd = {r_file, r_page, r_pin, 1'b0, r_ref};
            end
          end else if (r_pin == '0) begin
            st_d = StUnpinned;
          end else if (act_q == ActDirty) begin
            we = 1'b1; wd = {r_file, r_page, r_pin, 1'b1, 1'b1};
          end else begin
            we = 1'b1; wd = {r_file, r_page, r_pin - PIN_BITS'(1), r_dirty, 1'b0};
          end
        end
      end
      SSweep: begin
        // rd_q holds entry hand_q. Pinned frames are skipped, referenced ones
        // lose their reference bit, and the first other frame is evicted.
        if (r_pin != '0) begin
          cnt_d = cnt_q + SW'(1);
        end else if (r_ref) begin
          we = 1'b1; wa = hand_q; wd = {r_file, r_page, r_pin, r_dirty, 1'b0};
          cnt_d = cnt_q + SW'(1);
        end else begin
          we = 1'b1; wa = hand_q; wd = new_entry(file_q, page_q);
          st_d = StOk; fr_d = 4'(hand_q); fill_d = (act_q == ActGet);
          wb_d = r_dirty; wbf_d = r_dirty ? r_file : '0;
          wbp_d = r_dirty ? r_page : '0;
          ov_d = 1'b1;
        end
        if (!sweep_take) begin
          if (sweep_done) begin
            // Two full turns without a victim; the hand is back at its start.
            st_d = StNoFrame; fr_d = '0; ov_d = 1'b1;
          end else begin
            hand_d = hand_step(hand_q);
            ra = hand_step(hand_q);
          end
        end
      end
      SFile: begin
        // rd_q holds entry idx_q. A matching dirty frame is cleaned and kept
        // as the pending writeback; the one it replaces goes out, not last.
        if (!file_block) begin
          if (file_hit) begin
            we = 1'b1; wd = {r_file, r_page, r_pin, 1'b0, r_ref};
            nres_d = nres_q + 5'd1;
            if (pend_v_q) begin
              st_d = StOk; fr_d = 4'(pend_idx_q); fill_d = 1'b0; wb_d = 1'b1;
              wbf_d = file_q; wbp_d = pend_page_q; last_d = 1'b0; ov_d = 1'b1;
            end
            pend_v_d = 1'b1; pend_idx_d = idx_q; pend_page_d = r_page;
          end
          if (!scan_last) begin
            idx_d = idx_q + FW'(1);
            ra = idx_q + FW'(1);
          end
        end
      end
      SFileEnd: begin
        // The pending writeback, if any, is the final result.
        if (out_free) begin
          ov_d = 1'b1; last_d = 1'b1; st_d = StOk; fill_d = 1'b0;
          if (pend_v_q) begin
            fr_d = 4'(pend_idx_q); wb_d = 1'b1; wbf_d = file_q;
            wbp_d = pend_page_q;
          end else begin
            fr_d = '0; wb_d = 1'b0; wbf_d = '0; wbp_d = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      act_q <= '0; file_q <= '0; page_q <= '0;
      idx_q <= '0; hand_q <= '0; cnt_q <= '0;
      hit_q <= 1'b0; free_q <= 1'b0; hidx_q <= '0; fidx_q <= '0;
      nres_q <= '0; valid_q <= '0;
      pend_v_q <= 1'b0; pend_idx_q <= '0; pend_page_q <= '0;
      st_q <= '0; fr_q <= '0; fill_q <= 1'b0; wb_q <= 1'b0; last_q <= 1'b0;
      wbf_q <= '0; wbp_q <= '0; ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        act_q <= action_i; file_q <= file_id_i; page_q <= page_num_i;
      end
      idx_q <= idx_d; hand_q <= hand_d; cnt_q <= cnt_d;
      hit_q <= hit_d; free_q <= free_d; hidx_q <= hidx_d; fidx_q <= fidx_d;
      nres_q <= nres_d; valid_q <= valid_d;
      pend_v_q <= pend_v_d; pend_idx_q <= pend_idx_d; pend_page_q <= pend_page_d;
      st_q <= st_d; fr_q <= fr_d; fill_q <= fill_d; wb_q <= wb_d; last_q <= last_d;
      wbf_q <= wbf_d; wbp_q <= wbp_d; ov_q <= ov_d;
    end
  end

  assign out_valid_o        = ov_q;
  assign status_o           = st_q;
  assign frame_o            = fr_q;
  assign fill_needed_o      = fill_q;
  assign writeback_needed_o = wb_q;
  assign wb_file_id_o       = wbf_q;
  assign wb_page_num_o      = wbp_q;
  assign last_o             = last_q;
endmodule

// ===== sim/pfm_checker.sv =====
// Checker for the page frame manager: watches both channels, keeps its own copy
// of the frame table, predicts every result and compares field by field.
// Depends on pfm_pkg.
`timescale 1ns / 1ps
module pfm_checker
  import pfm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [2:0]  action_i,
  input  logic [7:0]  file_id_i,
  input  logic [23:0] page_num_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [2:0]  status_i,
  input  logic [3:0]  frame_i,
  input  logic        fill_needed_i,
  input  logic        writeback_needed_i,
  input  logic [7:0]  wb_file_id_i,
  input  logic [23:0] wb_page_num_i,
  input  logic        last_i,
  output int          fail_count_o,
  output int          pending_o
);
  localparam int NFrames = NumFramesDef;
  localparam logic [PinBitsDef-1:0] PinMax = '1;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  frame;
    logic        fill;
    logic        wb;
    logic [7:0]  wb_file;
    logic [23:0] wb_page;
    logic        last;
  } frame_result_t;

  logic                  tag_valid [NFrames];
  logic [7:0]            tag_file  [NFrames];
  logic [23:0]           tag_page  [NFrames];
  logic [PinBitsDef-1:0] pins      [NFrames];
  logic                  dirty     [NFrames];
  logic                  refd      [NFrames];
  logic [3:0]            hand;
  frame_result_t         expected_results[$];
  int                    fails = 0;

  assign pending_o = expected_results.size();
  assign fail_count_o = fails;

  function automatic frame_result_t mk(int st, int fr, int fl, int w, int wf, int wp,
                                       int l);
    frame_result_t r;
    r.status = 3'(st);
    r.frame = 4'(fr);
    r.fill = 1'(fl);
    r.wb = 1'(w);
    r.wb_file = 8'(wf);
    r.wb_page = 24'(wp);
    r.last = 1'(l);
    return r;
  endfunction

  task automatic reset_model();
    hand = 4'd0;
    expected_results.delete();
    for (int i = 0; i < NFrames; i++) begin
      tag_valid[i] = 1'b0; tag_file[i] = 8'd0; tag_page[i] = 24'd0;
      pins[i] = '0; dirty[i] = 1'b0; refd[i] = 1'b0;
    end
  endtask

  // Picks a frame for a miss: lowest free frame, else a two-turn clock sweep.
  function automatic bit pick_victim(output int slot);
    for (int i = 0; i < NFrames; i++) begin
      if (!tag_valid[i]) begin
        slot = i;
        return 1;
      end
    end
    for (int i = 0; i < SweepTurns * NFrames; i++) begin
      hand = hand + 4'd1;
      if (pins[hand] != '0) continue;
      if (refd[hand]) begin
        refd[hand] = 1'b0;
        continue;
      end
      slot = int'(hand);
      return 1;
    end
    slot = 0;
    return 0;
  endfunction

  task automatic load_frame(logic [7:0] f, logic [23:0] p, logic fill);
    int s;
    logic w;
    logic [7:0] wf;
    logic [23:0] wp;
    if (!pick_victim(s)) begin
      expected_results.push_back(mk(StNoFrame, 0, 0, 0, 0, 0, 1));
      return;
    end
    w = tag_valid[s] && dirty[s];
    wf = w ? tag_file[s] : 8'd0;
    wp = w ? tag_page[s] : 24'd0;
    tag_valid[s] = 1'b1;
    tag_file[s] = f;
    tag_page[s] = p;
    pins[s] = PinBitsDef'(1);
    dirty[s] = 1'b0;
    refd[s] = 1'b1;
    expected_results.push_back(mk(StOk, s, fill, w, wf, wp, 1));
  endtask

  task automatic predict_request(logic [2:0] act, logic [7:0] f, logic [23:0] p);
    int hit;
    int n;
    hit = -1;
    n = 0;
    if (act == ActForceFile) begin
      for (int i = 0; i < NFrames && n < MaxResults; i++) begin
        if (tag_valid[i] && tag_file[i] == f && dirty[i]) begin
          dirty[i] = 1'b0;
          expected_results.push_back(mk(StOk, i, 0, 1, tag_file[i], tag_page[i], 0));
          n++;
        end
      end
      if (n == 0) expected_results.push_back(mk(StOk, 0, 0, 0, 0, 0, 1));
      else expected_results[$].last = 1'b1;
      return;
    end
    if (act > ActForceFile) begin
      expected_results.push_back(mk(StNotIn, 0, 0, 0, 0, 0, 1));
      return;
    end
    for (int i = NFrames - 1; i >= 0; i--)
      if (tag_valid[i] && tag_file[i] == f && tag_page[i] == p) hit = i;
    case (act)
      ActGet: begin
        if (hit < 0) begin
          load_frame(f, p, 1'b1);
        end else if (pins[hit] >= PinMax) begin
          expected_results.push_back(mk(StPinLimit, hit, 0, 0, 0, 0, 1));
        end else begin
          pins[hit]++;
          refd[hit] = 1'b1;
          expected_results.push_back(mk(StOk, hit, 0, 0, 0, 0, 1));
        end
      end
      ActAlloc: begin
        if (hit >= 0) expected_results.push_back(mk(StAlready, hit, 0, 0, 0, 0, 1));
        else load_frame(f, p, 1'b0);
      end
      default: begin
        if (hit < 0) begin
          expected_results.push_back(mk(StNotIn, 0, 0, 0, 0, 0, 1));
        end else if (act == ActForce) begin
          if (dirty[hit]) begin
            dirty[hit] = 1'b0;
            expected_results.push_back(mk(StOk, hit, 0, 1, tag_file[hit],
                                          tag_page[hit], 1));
          end else begin
            expected_results.push_back(mk(StOk, hit, 0, 0, 0, 0, 1));
          end
        end else if (pins[hit] == '0) begin
          expected_results.push_back(mk(StUnpinned, hit, 0, 0, 0, 0, 1));
        end else begin
          if (act == ActDirty) begin
            dirty[hit] = 1'b1;
            refd[hit] = 1'b1;
          end else begin
            pins[hit]--;
            refd[hit] = 1'b0;
          end
          expected_results.push_back(mk(StOk, hit, 0, 0, 0, 0, 1));
        end
      end
    endcase
  endtask

  task automatic compare_result();
    frame_result_t e;
    if (expected_results.size() == 0) begin
      $error("unexpected result: status %0d frame %0d", status_i, frame_i);
      fails++;
      return;
    end
    e = expected_results.pop_front();
    if (status_i !== e.status) begin
      $error("status: expected %0d, got %0d", e.status, status_i); fails++;
    end
    if (frame_i !== e.frame) begin
      $error("frame: expected %0d, got %0d", e.frame, frame_i); fails++;
    end
    if (fill_needed_i !== e.fill) begin
      $error("fill_needed: expected %0d, got %0d", e.fill, fill_needed_i);
      fails++;
    end
    if (writeback_needed_i !== e.wb) begin
      $error("writeback_needed: expected %0d, got %0d", e.wb, writeback_needed_i);
      fails++;
    end
    if (wb_file_id_i !== e.wb_file) begin
      $error("wb_file_id: expected %0h, got %0h", e.wb_file, wb_file_id_i);
      fails++;
    end
    if (wb_page_num_i !== e.wb_page) begin
      $error("wb_page_num: expected %0h, got %0h", e.wb_page, wb_page_num_i);
      fails++;
    end
    if (last_i !== e.last) begin
      $error("last: expected %0d, got %0d", e.last, last_i); fails++;
    end
  endtask

  // Results are compared before the request of the same edge is predicted;
  // the block cannot return a result in the cycle it accepts the request.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      reset_model();
    end else begin
      if (out_valid_i && !out_stall_i) compare_result();
      if (in_valid_i && !in_stall_i) predict_request(action_i, file_id_i, page_num_i);
    end
  end
endmodule

// ===== sim/tb_page_frame_manager_clock.sv =====
// Top of the page frame manager regression: clock, reset, request stimulus,
// random stalls and the verdict. Depends on pfm_pkg, the block and pfm_checker.
`timescale 1ns / 1ps
module tb_page_frame_manager_clock;
  import pfm_pkg::*;

  // A request can give up to 16 results, each of which may wait out a random
  // stall burst or the long hold-off below.
  localparam int WatchdogLimit = 4000;
  localparam int LongHold = 300;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        in_valid_i = 0;
  logic        in_stall_o;
  logic [2:0]  action_i = '0;
  logic [7:0]  file_id_i = '0;
  logic [23:0] page_num_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 0;
  logic [2:0]  status_o;
  logic [3:0]  frame_o;
  logic        fill_needed_o;
  logic        writeback_needed_o;
  logic [7:0]  wb_file_id_o;
  logic [23:0] wb_page_num_o;
  logic        last_o;
  int          fail_count;
  int          pending;
  int          idle_cycles = 0;
  bit          quiet_phase = 0;
  bit          hold_request = 0;

  always begin
    #2 clk_i = 1;
    #2 clk_i = 0;
  end

  page_frame_manager_clock u_top (.*);

  pfm_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .action_i, .file_id_i,
    .page_num_i, .out_valid_i(out_valid_o), .out_stall_i, .status_i(status_o),
    .frame_i(frame_o), .fill_needed_i(fill_needed_o),
    .writeback_needed_i(writeback_needed_o), .wb_file_id_i(wb_file_id_o),
    .wb_page_num_i(wb_page_num_o), .last_i(last_o), .fail_count_o(fail_count),
    .pending_o(pending)
  );

  // The watchdog counts cycles in which neither channel moves a request or result.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("page_frame_manager_clock regression: fail");
      $finish;
    end
  end

  // Receiver side: random stall bursts, one long hold-off on request, and no
  // stalls once the quiet phase starts.
  initial begin
    int n;
    bit held;
    held = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_request && !held) begin
        held = 1;
        out_stall_i <= 1;
        for (int i = 0; i < LongHold; i++) @(negedge clk_i);
        out_stall_i <= 0;
      end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 12);
        out_stall_i <= 1;
        repeat (n) @(negedge clk_i);
        out_stall_i <= 0;
      end
    end
  end

  // Offers one request and holds it until the block takes it. A sender gap, if
  // any, comes before valid rises, so valid never drops between two requests
  // without a gap.
  task automatic send_request(logic [2:0] act, logic [7:0] f, logic [23:0] p);
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    in_valid_i <= 1;
    action_i <= act;
    file_id_i <= f;
    page_num_i <= p;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 0;
    while (pending != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
  endtask

  // Pages come from a small pool so that hits, evictions and force-file
  // writebacks happen often; the odd wide value still exercises every bit.
  function automatic logic [7:0] pick_file();
    return ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 2));
  endfunction

  function automatic logic [23:0] pick_page();
    return ($urandom_range(0, 9) == 0) ? 24'($urandom) : 24'($urandom_range(0, 11));
  endfunction

  initial begin
    logic [2:0] act;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);

    // Directed part: misses into free frames, hits, the extremes of the fields,
    // unknown actions, unpin and mark dirty of unpinned pages, forces.
    send_request(ActGet, 8'hFF, 24'hFFFFFF);
    send_request(ActGet, 8'hFF, 24'hFFFFFF);
    send_request(ActAlloc, 8'hFF, 24'hFFFFFF);
    send_request(ActAlloc, 8'h00, 24'h000000);
    send_request(ActDirty, 8'hFF, 24'hFFFFFF);
    send_request(ActForce, 8'hFF, 24'hFFFFFF);
    send_request(ActForce, 8'h00, 24'h000000);
    send_request(ActUnpin, 8'h00, 24'h000000);
    send_request(ActUnpin, 8'h00, 24'h000000);
    send_request(ActDirty, 8'h00, 24'h000000);
    send_request(ActDirty, 8'h12, 24'h345678);
    send_request(ActForceFile, 8'h77, 24'h0);
    send_request(3'd6, 8'hAA, 24'h555555);
    send_request(3'd7, 8'h55, 24'hAAAAAA);
    // Fill the remaining frames with pinned pages, so a further miss has to run the clock sweep.
    for (int i = 0; i < 14; i++) send_request(ActGet, 8'h01, 24'(i));
    send_request(ActGet, 8'h02, 24'h0);
    // Mark every page of file 1 dirty and unpin it, then force the whole file.
    for (int i = 0; i < 14; i++) begin
      send_request(ActDirty, 8'h01, 24'(i));
      send_request(ActUnpin, 8'h01, 24'(i));
    end
    send_request(ActForceFile, 8'h01, 24'h0);
    wait_drained();

    // Long receiver hold-off while the sender keeps offering requests.
    hold_request = 1;
    for (int i = 0; i < 10; i++) send_request(ActGet, pick_file(), pick_page());

    // Random part; unpins keep pin counts low enough for evictions to happen.
    for (int i = 0; i < 140; i++) begin
      if (i == 110) quiet_phase = 1;
      case ($urandom_range(0, 15))
        0, 1, 2, 3: act = ActGet;
        4, 5:       act = ActAlloc;
        6, 7:       act = ActDirty;
        8, 9, 10, 11: act = ActUnpin;
        12:         act = ActForce;
        13:         act = ActForceFile;
        14:         act = 3'($urandom_range(6, 7));
        default:    act = ActGet;
      endcase
      send_request(act, pick_file(), pick_page());
    end
    in_valid_i <= 0;
    while (pending != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);

    if (fail_count == 0) $display("page_frame_manager_clock regression: pass");
    else $display("page_frame_manager_clock regression: fail");
    $finish;
  end
endmodule
